/* sv/sot_pkg.sv */
// Shared constants, stage payload types and helpers for the shape overlap tester.
`timescale 1ns / 1ps

package sot_pkg;

  localparam int COORD_FRAC_BITS = 8;
  localparam int COORD_WIDTH     = 24;
  localparam int SIZE_WIDTH      = 12;

  // half size scaled to coordinate format
  localparam int HALF_W = SIZE_WIDTH - 1 + COORD_FRAC_BITS;
  // centre plus or minus a half size
  localparam int EDGE_W = ((COORD_WIDTH > HALF_W + 1) ? COORD_WIDTH : HALF_W + 1) + 1;
  localparam int RAD_W  = HALF_W + 1;
  localparam int DIFF_W = EDGE_W + 1;
  localparam int SQ_W   = 2 * RAD_W;
  localparam int SUM_W  = SQ_W + 1;

  typedef enum logic [2:0] {
    KIND_RECT_RECT    = 3'd0,
    KIND_RECT_CIRCLE  = 3'd1,
    KIND_CIRCLE_CIRCLE = 3'd2,
    KIND_POINT_RECT   = 3'd3,
    KIND_POINT_CIRCLE = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [EDGE_W-1:0]  l1;
    logic signed [EDGE_W-1:0]  r1;
    logic signed [EDGE_W-1:0]  t1;
    logic signed [EDGE_W-1:0]  b1;
    logic signed [EDGE_W-1:0]  l2;
    logic signed [EDGE_W-1:0]  r2;
    logic signed [EDGE_W-1:0]  t2;
    logic signed [EDGE_W-1:0]  b2;
    logic signed [COORD_WIDTH-1:0] x1;
    logic signed [COORD_WIDTH-1:0] y1;
    logic signed [COORD_WIDTH-1:0] x2;
    logic signed [COORD_WIDTH-1:0] y2;
    logic [RAD_W-1:0]          rad;
  } s1_t;

  typedef struct packed {
    kind_t                     kind;
    logic                      rr_hit;
    logic                      pr_hit;
    logic signed [DIFF_W-1:0]  dxl;
    logic signed [DIFF_W-1:0]  dxr;
    logic signed [DIFF_W-1:0]  dyt;
    logic signed [DIFF_W-1:0]  dyb;
    logic [RAD_W-1:0]          rad;
  } s2_t;

  typedef struct packed {
    kind_t             kind;
    logic              rr_hit;
    logic              pr_hit;
    logic              span;
    logic              box;
    logic [DIFF_W-1:0] axl;
    logic [DIFF_W-1:0] axr;
    logic [DIFF_W-1:0] ayt;
    logic [DIFF_W-1:0] ayb;
    logic [RAD_W-1:0]  rad;
  } s3_t;

  typedef struct packed {
    kind_t           kind;
    logic            rr_hit;
    logic            pr_hit;
    logic            span;
    logic            box;
    logic [3:0]      near;  // xl, xr, yt, yb within radius
    logic [SQ_W-1:0] sxl;
    logic [SQ_W-1:0] sxr;
    logic [SQ_W-1:0] syt;
    logic [SQ_W-1:0] syb;
    logic [SQ_W-1:0] r2;
  } s4_t;

  function automatic logic [HALF_W-1:0] half_size(input logic [SIZE_WIDTH-1:0] s);
    half_size = HALF_W'(s >> 1) << COORD_FRAC_BITS;
  endfunction

  function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
    mag = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
  endfunction

endpackage

/* sv/sot_edge.sv */
// First stage: half sizes, rectangle edges and test radius.
`timescale 1ns / 1ps

module sot_edge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [2:0]                           kind,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] x1,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] y1,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]       w1,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]       h1,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] x2,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] y2,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]       w2,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]       h2,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output sot_pkg::s1_t                         out_data
);
  import sot_pkg::*;

  logic                     valid_r;
  s1_t                      data_r;
  s1_t                      data_nxt;
  logic [HALF_W-1:0]        hw1, hh1, hw2, hh2;
  logic signed [EDGE_W-1:0] ex1, ey1, ex2, ey2;

  always_comb begin
    hw1 = half_size(w1);
    hh1 = half_size(h1);
    hw2 = half_size(w2);
    hh2 = half_size(h2);
    ex1 = EDGE_W'(x1);
    ey1 = EDGE_W'(y1);
    ex2 = EDGE_W'(x2);
    ey2 = EDGE_W'(y2);
    data_nxt.kind = kind_t'(kind);
    data_nxt.l1   = ex1 - $signed(EDGE_W'(hw1));
    data_nxt.r1   = ex1 + $signed(EDGE_W'(hw1));
    data_nxt.t1   = ey1 - $signed(EDGE_W'(hh1));
    data_nxt.b1   = ey1 + $signed(EDGE_W'(hh1));
    data_nxt.l2   = ex2 - $signed(EDGE_W'(hw2));
    data_nxt.r2   = ex2 + $signed(EDGE_W'(hw2));
    data_nxt.t2   = ey2 - $signed(EDGE_W'(hh2));
    data_nxt.b2   = ey2 + $signed(EDGE_W'(hh2));
    data_nxt.x1   = x1;
    data_nxt.y1   = y1;
    data_nxt.x2   = x2;
    data_nxt.y2   = y2;
    // circle-circle tests against the sum of both radii
    if (kind_t'(kind) == KIND_CIRCLE_CIRCLE) begin
      data_nxt.rad = RAD_W'(hw1) + RAD_W'(hw2);
    end else begin
      data_nxt.rad = RAD_W'(hw2);
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/sot_diff.sv */
// Second and third stages: edge compares, corner offsets, span and box checks.
`timescale 1ns / 1ps

module sot_diff (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sot_pkg::s1_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output sot_pkg::s3_t out_data
);
  import sot_pkg::*;

  logic                     v2_r, v3_r;
  logic                     rdy2, rdy3;
  s2_t                      s2_r, s2_nxt;
  s3_t                      s3_r, s3_nxt;
  logic signed [EDGE_W-1:0] ax, ay;
  logic signed [DIFF_W-1:0] rad_s;

  // stage 2
  always_comb begin
    // kinds other than rect-circle reuse the first corner slot for the centre offset
    if (in_data.kind == KIND_RECT_CIRCLE) begin
      ax = in_data.l1;
      ay = in_data.t1;
    end else begin
      ax = EDGE_W'(in_data.x1);
      ay = EDGE_W'(in_data.y1);
    end
    s2_nxt.kind   = in_data.kind;
    s2_nxt.rr_hit = (in_data.r1 >= in_data.l2) && (in_data.l1 <= in_data.r2) &&
                    (in_data.b1 >= in_data.t2) && (in_data.t1 <= in_data.b2);
    s2_nxt.pr_hit = (EDGE_W'(in_data.x1) >= in_data.l2) &&
                    (EDGE_W'(in_data.x1) <= in_data.r2) &&
                    (EDGE_W'(in_data.y1) >= in_data.t2) &&
                    (EDGE_W'(in_data.y1) <= in_data.b2);
    s2_nxt.dxl = DIFF_W'(ax) - DIFF_W'(in_data.x2);
    s2_nxt.dxr = DIFF_W'(in_data.r1) - DIFF_W'(in_data.x2);
    s2_nxt.dyt = DIFF_W'(ay) - DIFF_W'(in_data.y2);
    s2_nxt.dyb = DIFF_W'(in_data.b1) - DIFF_W'(in_data.y2);
    s2_nxt.rad = in_data.rad;
  end

  // stage 3
  always_comb begin
    rad_s         = $signed(DIFF_W'(s2_r.rad));
    s3_nxt.kind   = s2_r.kind;
    s3_nxt.rr_hit = s2_r.rr_hit;
    s3_nxt.pr_hit = s2_r.pr_hit;
    s3_nxt.span   = ((s2_r.dxl <= 0) && (s2_r.dxr >= 0)) ||
                    ((s2_r.dyt <= 0) && (s2_r.dyb >= 0));
    s3_nxt.box    = (s2_r.dxr >= -rad_s) && (s2_r.dxl <= rad_s) &&
                    (s2_r.dyb >= -rad_s) && (s2_r.dyt <= rad_s);
    s3_nxt.axl    = mag(s2_r.dxl);
    s3_nxt.axr    = mag(s2_r.dxr);
    s3_nxt.ayt    = mag(s2_r.dyt);
    s3_nxt.ayb    = mag(s2_r.dyb);
    s3_nxt.rad    = s2_r.rad;
  end

  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign in_ready  = rdy2;
  assign out_valid = v3_r;
  assign out_data  = s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) begin
        v2_r <= in_valid;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && in_valid) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      s3_r <= s3_nxt;
    end
  end

endmodule

/* sv/sot_square.sv */
// Fourth stage: squares of the corner offsets and the radius.
`timescale 1ns / 1ps

module sot_square (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  sot_pkg::s3_t in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output sot_pkg::s4_t out_data
);
  import sot_pkg::*;

  logic              valid_r;
  s4_t               data_r, data_nxt;
  logic [DIFF_W-1:0] rad_w;

  always_comb begin
    rad_w           = DIFF_W'(in_data.rad);
    data_nxt.kind   = in_data.kind;
    data_nxt.rr_hit = in_data.rr_hit;
    data_nxt.pr_hit = in_data.pr_hit;
    data_nxt.span   = in_data.span;
    data_nxt.box    = in_data.box;
    data_nxt.near   = {in_data.ayb <= rad_w, in_data.ayt <= rad_w,
                       in_data.axr <= rad_w, in_data.axl <= rad_w};
    // an offset beyond the radius misses anyway, so its square may wrap
    data_nxt.sxl = SQ_W'(in_data.axl[RAD_W-1:0]) * SQ_W'(in_data.axl[RAD_W-1:0]);
    data_nxt.sxr = SQ_W'(in_data.axr[RAD_W-1:0]) * SQ_W'(in_data.axr[RAD_W-1:0]);
    data_nxt.syt = SQ_W'(in_data.ayt[RAD_W-1:0]) * SQ_W'(in_data.ayt[RAD_W-1:0]);
    data_nxt.syb = SQ_W'(in_data.ayb[RAD_W-1:0]) * SQ_W'(in_data.ayb[RAD_W-1:0]);
    data_nxt.r2  = SQ_W'(in_data.rad) * SQ_W'(in_data.rad);
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* sv/shape_overlap_tester_unit.sv */
// Top level of the shape overlap tester: pipeline stages and the output register.
//
// Each input item asks one overlap test (rect-rect, rect-circle, circle-circle,
// point-rect or point-circle, chosen by in_kind) and gives one result item,
// out_hit, set when the shapes touch or overlap. Unused kinds give a miss.
// Both channels are valid/ready; an item moves when valid and ready are high.
// The datapath is five register stages: edges, edge compares and offsets,
// magnitudes and box checks, squares, then the distance compare that loads
// the output register; out_valid rises when that register is loaded.
// Throughput is one item per cycle while out_ready stays high; the 20 by 20
// bit squarers in the fourth stage set the critical path.
// A stall on the output holds every full stage; empty stages keep filling,
// so up to five items sit in flight while in_ready is low, and none is lost.
// Synchronous reset clears all stage valid bits; nothing else needs clearing.
`timescale 1ns / 1ps

module shape_overlap_tester_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [2:0]                             in_kind,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] in_first_x,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] in_first_y,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]         in_first_width,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]         in_first_height,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] in_second_x,
  input  logic signed [sot_pkg::COORD_WIDTH-1:0] in_second_y,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]         in_second_width,
  input  logic [sot_pkg::SIZE_WIDTH-1:0]         in_second_height,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_hit
);
  import sot_pkg::*;

  logic             v1, r1, v3, r3, v4, r4;
  s1_t              d1;
  s3_t              d3;
  s4_t              d4;
  logic             valid_r;
  logic             hit_r, hit_nxt;
  logic [3:0]       corner;
  logic [SUM_W-1:0] r2_w;

  sot_edge u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (in_kind),
    .x1        (in_first_x),
    .y1        (in_first_y),
    .w1        (in_first_width),
    .h1        (in_first_height),
    .x2        (in_second_x),
    .y2        (in_second_y),
    .w2        (in_second_width),
    .h2        (in_second_height),
    .out_valid (v1),
    .out_ready (r1),
    .out_data  (d1)
  );

  sot_diff u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1),
    .in_ready  (r1),
    .in_data   (d1),
    .out_valid (v3),
    .out_ready (r3),
    .out_data  (d3)
  );

  sot_square u_square (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3),
    .in_ready  (r3),
    .in_data   (d3),
    .out_valid (v4),
    .out_ready (r4),
    .out_data  (d4)
  );

  // corners: left-top, left-bottom, right-top, right-bottom
  always_comb begin
    r2_w      = SUM_W'(d4.r2);
    corner[0] = d4.near[0] && d4.near[2] && (SUM_W'(d4.sxl) + SUM_W'(d4.syt) <= r2_w);
    corner[1] = d4.near[0] && d4.near[3] && (SUM_W'(d4.sxl) + SUM_W'(d4.syb) <= r2_w);
    corner[2] = d4.near[1] && d4.near[2] && (SUM_W'(d4.sxr) + SUM_W'(d4.syt) <= r2_w);
    corner[3] = d4.near[1] && d4.near[3] && (SUM_W'(d4.sxr) + SUM_W'(d4.syb) <= r2_w);
    case (d4.kind)
      KIND_RECT_RECT:     hit_nxt = d4.rr_hit;
      KIND_RECT_CIRCLE:   hit_nxt = d4.span ? d4.box : (|corner);
      KIND_CIRCLE_CIRCLE: hit_nxt = corner[0];
      KIND_POINT_RECT:    hit_nxt = d4.pr_hit;
      KIND_POINT_CIRCLE:  hit_nxt = corner[0];
      default:            hit_nxt = 1'b0;
    endcase
  end

  assign r4        = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_hit   = hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (r4) begin
      valid_r <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (r4 && v4) begin
      hit_r <= hit_nxt;
    end
  end

endmodule
